>>> design/sdrc_pkg.sv
// ----------------------------------------------------------------------------
// sdrc_pkg
// types, constants and register codes of the stereo dynamic range compressor
// ----------------------------------------------------------------------------
`default_nettype none

package sdrc_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int LEVEL_BITS_DEF  = 32;
  localparam int REG_BITS        = 32;
  localparam int IDX_BITS        = 3;
  localparam int GAIN_FRAC       = 24;
  localparam int DIV_BITS        = 64;

  localparam logic [IDX_BITS-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_RATIO     = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_STEP      = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_RISE      = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_FALL      = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_VOLUME    = 3'd5;

  localparam logic [REG_BITS-1:0] THRESHOLD_RST = 32'd13421773;
  localparam logic [REG_BITS-1:0] RATIO_RST     = 32'd32768000;
  localparam logic [REG_BITS-1:0] STEP_RST      = 32'd6554;
  localparam logic [REG_BITS-1:0] RISE_RST      = 32'd28901;
  localparam logic [REG_BITS-1:0] FALL_RST      = 32'd289013760;
  localparam logic [REG_BITS-1:0] VOLUME_RST    = 32'd65536;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] left_sample;
    logic signed [SAMPLE_BITS_DEF-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] left_out;
    logic signed [SAMPLE_BITS_DEF-1:0] right_out;
  } out_item_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // take magnitude, level, threshold for current channel
    OP_ENV_DIV,   // start envelope quotient
    OP_ENV_UPD,   // apply envelope update
    OP_SR_MUL,    // step * ratio
    OP_EXC_DIV,   // start excess quotient
    OP_NUM,       // thr + q, start gain quotient
    OP_GAIN_LO,   // magnitude * low half of gain
    OP_GAIN_MUL,  // magnitude * gain
    OP_VOL_LO,    // low half of magnitude * volume
    OP_VOL_MUL,   // magnitude * volume
    OP_STORE      // saturate, sign, store result
  } op_t;

  typedef struct packed {
    op_t  op;
    logic chan;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic above_thr;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> design/sdrc_div.sv
// ----------------------------------------------------------------------------
// sdrc_div
// shared restoring divider, floor(n * 2^sh / d) saturated, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sdrc_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [sdrc_pkg::DIV_BITS-1:0]  num,
  input  wire logic [6:0]                     shift,
  input  wire logic [sdrc_pkg::DIV_BITS-1:0]  den,
  output logic                                busy,
  output logic [sdrc_pkg::DIV_BITS-1:0]       quot
);

  localparam int W = sdrc_pkg::DIV_BITS;

  logic [W-1:0] n_r, d_r, r_r, q_r;
  logic [7:0]   cnt_r;
  logic         sat_r, busy_r, zero_r;
  logic [W:0]   r_sh;
  logic         take;

  always_comb begin
    r_sh = {r_r, n_r[W-1]};
    take = r_sh[W] || (r_sh[W-1:0] >= d_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 8'(W) + 8'(shift);
      n_r    <= num;
      d_r    <= den;
      r_r    <= '0;
      q_r    <= '0;
      sat_r  <= 1'b0;
      zero_r <= (den == '0);
    end else if (busy_r) begin
      n_r   <= {n_r[W-2:0], 1'b0};
      r_r   <= take ? (r_sh[W-1:0] - d_r) : r_sh[W-1:0];
      q_r   <= {q_r[W-2:0], take};
      sat_r <= sat_r | q_r[W-1];
      cnt_r <= cnt_r - 8'd1;
      if (cnt_r == 8'd1 || zero_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = (sat_r || zero_r) ? '1 : q_r;

endmodule

`default_nettype wire

>>> design/sdrc_datapath.sv
// ----------------------------------------------------------------------------
// sdrc_datapath
// level, gain and volume arithmetic for both channels, one step per command
// ----------------------------------------------------------------------------
`default_nettype none

module sdrc_datapath #(
  parameter int SAMPLE_BITS = sdrc_pkg::SAMPLE_BITS_DEF,
  parameter int LEVEL_BITS  = sdrc_pkg::LEVEL_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sdrc_pkg::dp_cmd_t             cmd,
  output sdrc_pkg::dp_stat_t                 stat,
  input  wire logic [SAMPLE_BITS-1:0]        smp_l,
  input  wire logic [SAMPLE_BITS-1:0]        smp_r,
  input  wire logic [sdrc_pkg::REG_BITS-1:0] thr_cfg,
  input  wire logic [sdrc_pkg::REG_BITS-1:0] ratio_cfg,
  input  wire logic [sdrc_pkg::REG_BITS-1:0] step_cfg,
  input  wire logic [sdrc_pkg::REG_BITS-1:0] rise_cfg,
  input  wire logic [sdrc_pkg::REG_BITS-1:0] fall_cfg,
  input  wire logic [sdrc_pkg::REG_BITS-1:0] vol_cfg,
  output logic [SAMPLE_BITS-1:0]             res_l,
  output logic [SAMPLE_BITS-1:0]             res_r
);

  localparam int W        = sdrc_pkg::DIV_BITS;
  localparam int LVL_FRAC = LEVEL_BITS - 8;
  localparam int SMP_FRAC = SAMPLE_BITS - 1;
  localparam logic [W-1:0] LVL_MAX = W'((65'd1 << LEVEL_BITS) - 65'd1);
  localparam logic [W-1:0] LIM_POS = W'((65'd1 << (SAMPLE_BITS - 1)) - 65'd1);
  localparam logic [W-1:0] LIM_NEG = W'(65'd1 << (SAMPLE_BITS - 1));

  logic [W-1:0] lvl_r [2];
  logic [W-1:0] magl_r, lv_r, thr_r, m_r, sr_r, aux_r, lo_r;
  logic         neg_r, rise_r;
  logic [SAMPLE_BITS-1:0] res_r_l, res_r_r;

  logic         dv_start;
  logic [W-1:0] dv_num, dv_den, dv_q;
  logic [6:0]   dv_sh;
  logic         dv_busy;

  logic [SAMPLE_BITS-1:0] smp;
  logic [W-1:0]           mag_c, magl_c, thr_c, lim_c, sum_c, mres;
  logic [31:0]            mul_s, mul_b;
  logic [W-1:0]           prod, full_c;
  logic [W:0]             sum_w, full_w;

  function automatic logic [W-1:0] shift_into(input logic [W-1:0] v,
                                               input int from_f, input int to_f);
    logic [W-1:0] o;
    if (to_f >= from_f) o = v << (to_f - from_f);
    else o = v >> (from_f - to_f);
    return o;
  endfunction

  sdrc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .shift (dv_sh),
    .den   (dv_den),
    .busy  (dv_busy),
    .quot  (dv_q)
  );

  always_comb begin
    smp    = cmd.chan ? smp_r : smp_l;
    mag_c  = smp[SAMPLE_BITS-1] ? W'(-smp) & W'({SAMPLE_BITS{1'b1}}) : W'(smp);
    magl_c = shift_into(mag_c, SMP_FRAC, LVL_FRAC);
    thr_c  = shift_into(W'(thr_cfg), 24, LVL_FRAC);
    sum_w  = {1'b0, thr_r} + {1'b0, dv_q};
    sum_c  = sum_w[W] ? '1 : sum_w[W-1:0];
    lim_c  = neg_r ? LIM_NEG : LIM_POS;
    mres   = (m_r > lim_c) ? lim_c : m_r;
  end

  // one shared 32 by 32 multiplier, wide products taken in two halves
  always_comb begin
    mul_s = m_r[31:0];
    mul_b = aux_r[31:0];
    unique case (cmd.op)
      sdrc_pkg::OP_SR_MUL: begin
        mul_s = step_cfg;
        mul_b = ratio_cfg;
      end
      sdrc_pkg::OP_GAIN_MUL: mul_b = aux_r[W-1:32];
      sdrc_pkg::OP_VOL_LO: begin
        mul_s = aux_r[31:0];
        mul_b = m_r[31:0];
      end
      sdrc_pkg::OP_VOL_MUL: begin
        mul_s = aux_r[31:0];
        mul_b = m_r[W-1:32];
      end
      default: ;
    endcase
    prod   = W'(mul_s) * W'(mul_b);
    full_w = {1'b0, lo_r} + {1'b0, prod[31:0], 32'd0};
    full_c = ((prod[W-1:32] != '0) || full_w[W]) ? '1 : full_w[W-1:0];
  end

  always_comb begin
    dv_start = 1'b0;
    dv_num   = magl_r;
    dv_den   = rise_r ? W'(rise_cfg) : W'(fall_cfg);
    dv_sh    = 7'd16;
    unique case (cmd.op)
      sdrc_pkg::OP_ENV_DIV: dv_start = 1'b1;
      sdrc_pkg::OP_EXC_DIV: begin
        dv_start = 1'b1;
        dv_num   = lv_r - thr_r;
        dv_den   = sr_r;
        dv_sh    = 7'd32;
      end
      sdrc_pkg::OP_NUM: begin
        dv_start = 1'b1;
        dv_num   = sum_c;
        dv_den   = lv_r;
        dv_sh    = 7'(sdrc_pkg::GAIN_FRAC);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r[0] <= '0;
      lvl_r[1] <= '0;
    end else begin
      unique case (cmd.op)
        sdrc_pkg::OP_LOAD: begin
          m_r    <= mag_c;
          magl_r <= magl_c;
          neg_r  <= smp[SAMPLE_BITS-1];
          lv_r   <= lvl_r[cmd.chan];
          thr_r  <= thr_c;
          rise_r <= magl_c >= lvl_r[cmd.chan];
        end
        sdrc_pkg::OP_ENV_UPD: begin
          logic [W:0]   up;
          logic [W-1:0] nl;
          up = {1'b0, lv_r} + {1'b0, dv_q};
          if (rise_r) nl = (up[W] || up[W-1:0] > LVL_MAX) ? LVL_MAX : up[W-1:0];
          else nl = (dv_q >= lv_r) ? '0 : lv_r - dv_q;
          lv_r <= nl;
          lvl_r[cmd.chan] <= nl;
        end
        sdrc_pkg::OP_SR_MUL: sr_r <= prod;
        sdrc_pkg::OP_GAIN_LO, sdrc_pkg::OP_VOL_LO: lo_r <= prod;
        sdrc_pkg::OP_GAIN_MUL: begin
          if (lv_r > thr_r) begin
            m_r <= full_c >> sdrc_pkg::GAIN_FRAC;
          end
        end
        sdrc_pkg::OP_VOL_MUL: begin
          m_r <= full_c >> 16;
        end
        sdrc_pkg::OP_STORE: begin
          if (cmd.chan) res_r_r <= neg_r ? SAMPLE_BITS'(-mres) : SAMPLE_BITS'(mres);
          else res_r_l <= neg_r ? SAMPLE_BITS'(-mres) : SAMPLE_BITS'(mres);
        end
        default: ;
      endcase
    end
  end

  // second multiplier operand follows the step in progress
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      sdrc_pkg::OP_NUM, sdrc_pkg::OP_EXC_DIV:    aux_r <= '0;
      sdrc_pkg::OP_GAIN_MUL:                     aux_r <= W'(vol_cfg);
      sdrc_pkg::OP_VOL_LO, sdrc_pkg::OP_VOL_MUL: aux_r <= aux_r;
      default:                                   aux_r <= dv_busy ? aux_r : dv_q;
    endcase
  end

  assign stat.div_busy  = dv_busy;
  assign stat.above_thr = lv_r > thr_r;
  assign res_l = res_r_l;
  assign res_r = res_r_r;

endmodule

`default_nettype wire

>>> design/sdrc_ctrl.sv
// ----------------------------------------------------------------------------
// sdrc_ctrl
// sequencer: walks both channels through level, gain and volume steps
// ----------------------------------------------------------------------------
`default_nettype none

module sdrc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic               out_fire,
  input  wire sdrc_pkg::dp_stat_t stat,
  output sdrc_pkg::dp_cmd_t       cmd,
  output logic                    in_ready,
  output logic                    out_valid
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_LOAD     = 4'd1;
  localparam logic [3:0] S_ENV_DIV  = 4'd2;
  localparam logic [3:0] S_ENV_WAIT = 4'd3;
  localparam logic [3:0] S_ENV_UPD  = 4'd4;
  localparam logic [3:0] S_SR       = 4'd5;
  localparam logic [3:0] S_EXC_DIV  = 4'd6;
  localparam logic [3:0] S_EXC_WAIT = 4'd7;
  localparam logic [3:0] S_NUM      = 4'd8;
  localparam logic [3:0] S_G_WAIT   = 4'd9;
  localparam logic [3:0] S_GAIN     = 4'd10;
  localparam logic [3:0] S_VOL      = 4'd11;
  localparam logic [3:0] S_STORE    = 4'd12;
  localparam logic [3:0] S_SETTLE   = 4'd13;
  localparam logic [3:0] S_GAIN_LO  = 4'd14;
  localparam logic [3:0] S_VOL_LO   = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       chan_r, chan_nxt;
  logic       ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    ov_nxt    = ov_r & ~out_fire;
    cmd.op    = sdrc_pkg::OP_NONE;
    cmd.chan  = chan_r;
    unique case (state_r)
      S_IDLE:     if (in_fire) begin state_nxt = S_LOAD; chan_nxt = 1'b0; end
      S_LOAD:     begin cmd.op = sdrc_pkg::OP_LOAD; state_nxt = S_ENV_DIV; end
      S_ENV_DIV:  begin cmd.op = sdrc_pkg::OP_ENV_DIV; state_nxt = S_ENV_WAIT; end
      S_ENV_WAIT: if (!stat.div_busy) state_nxt = S_ENV_UPD;
      S_ENV_UPD:  begin cmd.op = sdrc_pkg::OP_ENV_UPD; state_nxt = S_SR; end
      S_SR: begin
        cmd.op    = sdrc_pkg::OP_SR_MUL;
        state_nxt = stat.above_thr ? S_EXC_DIV : S_SETTLE;
      end
      S_EXC_DIV:  begin cmd.op = sdrc_pkg::OP_EXC_DIV; state_nxt = S_EXC_WAIT; end
      S_EXC_WAIT: if (!stat.div_busy) state_nxt = S_NUM;
      S_NUM:      begin cmd.op = sdrc_pkg::OP_NUM; state_nxt = S_G_WAIT; end
      S_G_WAIT:   if (!stat.div_busy) state_nxt = S_SETTLE;
      S_SETTLE:   state_nxt = S_GAIN_LO;
      S_GAIN_LO:  begin cmd.op = sdrc_pkg::OP_GAIN_LO; state_nxt = S_GAIN; end
      S_GAIN:     begin cmd.op = sdrc_pkg::OP_GAIN_MUL; state_nxt = S_VOL_LO; end
      S_VOL_LO:   begin cmd.op = sdrc_pkg::OP_VOL_LO; state_nxt = S_VOL; end
      S_VOL:      begin cmd.op = sdrc_pkg::OP_VOL_MUL; state_nxt = S_STORE; end
      S_STORE: begin
        // wait while the previous result is still on offer
        if (!ov_r || out_fire) begin
          cmd.op = sdrc_pkg::OP_STORE;
          if (chan_r) begin
            state_nxt = S_IDLE;
            ov_nxt    = 1'b1;
          end else begin
            chan_nxt  = 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chan_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chan_r  <= chan_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

endmodule

`default_nettype wire

>>> design/stereo_dynamic_range_compressor.sv
// ----------------------------------------------------------------------------
// stereo_dynamic_range_compressor
// per-channel envelope follower with threshold compression and volume
//
//   channel  ports                         role
//   in       in_valid/in_ready/in_data     stereo frame in
//   out      out_valid/out_ready/out_data  compressed frame out
//   cfg      cfg_we/cfg_index/cfg_data     register writes, no read-back
//
// the time from accepted frame to result grows when a channel's level is above
// the threshold (excess and gain quotients added) and shrinks when a divisor is
// zero; the shared bit-serial divider forms every quotient, channels in turn
// synchronous reset clears both levels and loads register defaults
// a new frame is taken while the last result waits; storing stalls until taken
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_dynamic_range_compressor #(
  parameter int LEVEL_BITS  = sdrc_pkg::LEVEL_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire sdrc_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sdrc_pkg::out_item_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [sdrc_pkg::IDX_BITS-1:0] cfg_index,
  input  wire logic [sdrc_pkg::REG_BITS-1:0] cfg_data
);

  logic [sdrc_pkg::REG_BITS-1:0] thr_r, ratio_r, step_r, rise_r, fall_r, vol_r;
  sdrc_pkg::in_item_t  smp_r;
  sdrc_pkg::dp_cmd_t   cmd;
  sdrc_pkg::dp_stat_t  stat;
  logic                in_fire, out_fire;
  logic [sdrc_pkg::SAMPLE_BITS_DEF-1:0] res_l, res_r;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= sdrc_pkg::THRESHOLD_RST;
      ratio_r <= sdrc_pkg::RATIO_RST;
      step_r  <= sdrc_pkg::STEP_RST;
      rise_r  <= sdrc_pkg::RISE_RST;
      fall_r  <= sdrc_pkg::FALL_RST;
      vol_r   <= sdrc_pkg::VOLUME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdrc_pkg::REG_THRESHOLD: thr_r   <= cfg_data;
        sdrc_pkg::REG_RATIO:     ratio_r <= cfg_data;
        sdrc_pkg::REG_STEP:      step_r  <= cfg_data;
        sdrc_pkg::REG_RISE:      rise_r  <= cfg_data;
        sdrc_pkg::REG_FALL:      fall_r  <= cfg_data;
        sdrc_pkg::REG_VOLUME:    vol_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) smp_r <= in_data;
  end

  sdrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  sdrc_datapath #(
    .SAMPLE_BITS (sdrc_pkg::SAMPLE_BITS_DEF),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .smp_l     (smp_r.left_sample),
    .smp_r     (smp_r.right_sample),
    .thr_cfg   (thr_r),
    .ratio_cfg (ratio_r),
    .step_cfg  (step_r),
    .rise_cfg  (rise_r),
    .fall_cfg  (fall_r),
    .vol_cfg   (vol_r),
    .res_l     (res_l),
    .res_r     (res_r)
  );

  assign out_data.left_out  = res_l;
  assign out_data.right_out = res_r;

endmodule

`default_nettype wire

>>> dv/sdrc_checker.sv
// ----------------------------------------------------------------------------
// sdrc_checker
// watches the frame, result and register ports of the stereo compressor,
// keeps its own copy of registers and channel levels, predicts each
// compressed frame and compares it field by field in arrival order
// ----------------------------------------------------------------------------
module sdrc_checker
  import sdrc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0] cfg_data,
  output int                  fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ALL_ONES  = '1;
  localparam logic [63:0] LEVEL_TOP = 64'hFFFF_FFFF;

  logic [31:0] thr_reg, ratio_reg, step_reg, rise_reg, fall_reg, vol_reg;
  logic [63:0] left_level, right_level;
  out_item_t   frames_due[$];

  // floor(n * 2^sh / d), saturating
  function automatic logic [63:0] quot_sat(input logic [63:0] n, input int sh,
                                           input logic [63:0] d);
    logic [63:0] q, r;
    logic        carry, bitv, sat;
    q = '0;
    r = '0;
    sat = 1'b0;
    if (d == 0) return ALL_ONES;
    for (int i = 0; i < 64 + sh; i++) begin
      bitv = (i < 64) ? n[63-i] : 1'b0;
      carry = r[63];
      r = {r[62:0], bitv};
      if (carry || r >= d) begin
        r = r - d;
        if (q[63]) sat = 1'b1;
        q = {q[62:0], 1'b1};
      end else begin
        if (q[63]) sat = 1'b1;
        q = {q[62:0], 1'b0};
      end
    end
    return sat ? ALL_ONES : q;
  endfunction

  function automatic logic [63:0] prod_sat(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return (p[127:64] != 0) ? ALL_ONES : p[63:0];
  endfunction

  function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return s[64] ? ALL_ONES : s[63:0];
  endfunction

  function automatic logic [23:0] compress_sample(input logic [23:0] raw,
                                                  inout logic [63:0] lvl);
    logic        neg;
    logic [63:0] mag, magl, thr, d, sr, q, g, m, lim;
    neg  = raw[23];
    mag  = neg ? {40'd0, -raw} : {40'd0, raw};
    if (raw == 24'h800000) mag = 64'h80_0000;
    magl = mag << 1;
    thr  = {32'd0, thr_reg};
    if (magl >= lvl) begin
      d   = quot_sat(magl, 16, {32'd0, rise_reg});
      lvl = sum_sat(lvl, d);
      if (lvl > LEVEL_TOP) lvl = LEVEL_TOP;
    end else begin
      d   = quot_sat(magl, 16, {32'd0, fall_reg});
      lvl = (d >= lvl) ? 64'd0 : lvl - d;
    end
    m = mag;
    if (lvl > thr) begin
      sr = {32'd0, step_reg} * {32'd0, ratio_reg};
      q  = quot_sat(lvl - thr, 32, sr);
      g  = quot_sat(sum_sat(thr, q), GAIN_FRAC, lvl);
      m  = prod_sat(m, g) >> GAIN_FRAC;
    end
    m   = prod_sat(m, {32'd0, vol_reg}) >> 16;
    lim = neg ? 64'h80_0000 : 64'h7F_FFFF;
    if (m > lim) m = lim;
    return neg ? -m[23:0] : m[23:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want, got;
    if (!rst_n) begin
      thr_reg     <= THRESHOLD_RST;
      ratio_reg   <= RATIO_RST;
      step_reg    <= STEP_RST;
      rise_reg    <= RISE_RST;
      fall_reg    <= FALL_RST;
      vol_reg     <= VOLUME_RST;
      left_level  <= '0;
      right_level <= '0;
      frames_due.delete();
      fail_count  <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: thr_reg   <= cfg_data;
          REG_RATIO:     ratio_reg <= cfg_data;
          REG_STEP:      step_reg  <= cfg_data;
          REG_RISE:      rise_reg  <= cfg_data;
          REG_FALL:      fall_reg  <= cfg_data;
          REG_VOLUME:    vol_reg   <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        logic [63:0] ll, rl;
        ll = left_level;
        rl = right_level;
        want.left_out  = compress_sample(in_data.left_sample, ll);
        want.right_out = compress_sample(in_data.right_sample, rl);
        left_level  <= ll;
        right_level <= rl;
        frames_due.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (frames_due.size() == 0) begin
          $display("unexpected transaction on output at %0t", $time);
          fail_count++;
        end else begin
          want = frames_due.pop_front();
          if (got.left_out !== want.left_out)
            report_mismatch("left_out", got.left_out, want.left_out);
          if (got.right_out !== want.right_out)
            report_mismatch("right_out", got.right_out, want.right_out);
        end
      end
    end
  end

  final if (frames_due.size() != 0) ;
endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives stereo frames and register settings into the compressor with random
// gaps and output stalls, one long output hold-off, and gives the verdict
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sdrc_pkg::*;

  localparam logic [IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_CYCLES = 1500;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = '0;
  logic [REG_BITS-1:0] cfg_data = '0;
  int                  fail_count;
  int                  frames_sent = 0;
  int                  frames_back = 0;
  int                  idle_cycles = 0;
  logic                hold_req = 1'b0;
  logic                hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stereo_dynamic_range_compressor u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  sdrc_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_index, .cfg_data, .fail_count
  );

  always @(posedge clk) begin
    if (out_valid && out_ready) frames_back <= frames_back + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side, with one long hold-off on request
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_done <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_frame(input logic [23:0] l, input logic [23:0] r, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{left_sample: l, right_sample: r};
    do @(posedge clk); while (!in_ready);
    frames_sent++;
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 3))
      0:       return 24'($urandom_range(0, 4095) - 2048);
      1:       return $urandom_range(0, 1) ? 24'(24'h800000 + $urandom_range(0, 65535))
                                           : 24'(24'h7FFFFF - $urandom_range(0, 65535));
      default: return 24'($urandom);
    endcase
  endfunction

  // write enable stays high; the caller drops it after the last write
  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (frames_back == frames_sent);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] thr, ratio, step, rise, fall, vol);
    settle();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_RATIO, ratio);
    write_reg(REG_STEP, step);
    write_reg(REG_RISE, rise);
    write_reg(REG_FALL, fall);
    write_reg(REG_VOLUME, vol);
  endtask

  task automatic random_frames(input int count);
    bit burst;
    for (int i = 0; i < count; i++) begin
      burst = ($urandom_range(0, 9) < 2);
      send_frame(pick_sample(), pick_sample(), burst);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults, extremes of the samples
    send_frame(24'h000000, 24'h000000, 0);
    send_frame(24'h7FFFFF, 24'h800000, 0);
    send_frame(24'h800000, 24'h7FFFFF, 0);
    send_frame(24'hFFFFFF, 24'h000001, 1);
    send_frame(24'h000001, 24'hFFFFFF, 0);
    for (int i = 0; i < 6; i++) send_frame(24'h7FFFFF, 24'h800000, 1);
    send_frame(24'h000000, 24'h000010, 0);
    send_frame(24'h555555, 24'hAAAAAA, 0);
    send_frame(24'hAAAAAA, 24'h555555, 0);
    for (int i = 0; i < 4; i++) send_frame(24'h000000, 24'h000000, 1);

    // extremes: fastest level, smallest step and ratio, loudest volume
    load_regs(32'd0, 32'd1, 32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    random_frames(60);
    // largest registers, muted output
    load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'd0);
    cfg_we <= 1'b0;
    random_frames(60);
    // zero rise, fall, step and ratio; spare indexes are ignored
    load_regs(THRESHOLD_RST, 32'd0, 32'd0, 32'd0, 32'd0, VOLUME_RST);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h1234_5678);
    cfg_we <= 1'b0;
    random_frames(60);

    for (int p = 0; p < 6; p++) begin
      load_regs($urandom_range(0, 32'h0400_0000), $urandom_range(32'h1_0000, 32'h14_0000),
                $urandom_range(6554, 32'h1_0000), $urandom_range(1, 32'h40_0000),
                $urandom_range(32'h1_0000, 32'h400_0000),
                $urandom_range(32'h8000, 32'h4_0000));
      cfg_we <= 1'b0;
      if (p == 2) hold_req <= 1'b1;
      random_frames(145);
    end

    settle();
    repeat (500) @(posedge clk);
    if (fail_count == 0 && frames_back == frames_sent) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
